// File: rtl/core/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_DEPTH   = 2;
  localparam int CPTR_W      = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CCNT_W      = $clog2(CMD_DEPTH + 1);

  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int COUNT_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_THR_RST = 16'd1000;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd300;
  localparam logic             PRESSED_RST  = 1'b0;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_POLL = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SHORT = 1'b0,
    KIND_LONG  = 1'b1
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG_THR = 2'd1,
    REG_RELEASE  = 2'd2,
    REG_PRESSED  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_threshold_ms;
    logic [CFG_W-1:0] release_delay_ms;
    logic             pressed_level;
  } cfg_t;

  // Work for the back end: either a popped edge time or a check at poll time
  typedef struct packed {
    logic              pop;
    logic [TIME_W-1:0] stamp;
    logic              level;
  } cmd_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// File: rtl/core/bpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_front
// Debounces edge transactions into the edge-time queue and turns each poll
// into a command for the back end.
// ----------------------------------------------------------------------------
module bpc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  bpc_pkg::cfg_t              cfg,
  input  logic                       item_valid,
  input  logic                       op,
  input  logic [bpc_pkg::TIME_W-1:0] time_ms,
  input  logic                       button_level,
  output logic                       push,
  output bpc_pkg::cmd_t              cmd
);

  logic [bpc_pkg::TIME_W-1:0]  edge_queue [bpc_pkg::QUEUE_DEPTH];
  logic [bpc_pkg::TIME_W-1:0]  last_edge_time;
  logic [bpc_pkg::QPTR_W-1:0]  queue_head;
  logic [bpc_pkg::QPTR_W-1:0]  queue_tail;
  logic [bpc_pkg::QFILL_W-1:0] queue_fill;

  logic [bpc_pkg::TIME_W-1:0]  gap;
  logic                        is_edge;
  logic                        edge_ok;
  logic                        enq;
  logic                        deq;

  assign is_edge = item_valid && (op == bpc_pkg::OP_EDGE);
  assign gap     = time_ms - last_edge_time;
  assign edge_ok = is_edge && (gap > {16'd0, cfg.debounce_ms});
  assign enq     = edge_ok && (queue_fill < bpc_pkg::QFILL_W'(bpc_pkg::QUEUE_DEPTH));
  assign deq     = item_valid && (op == bpc_pkg::OP_POLL) && (queue_fill != '0);

  assign push      = item_valid && (op == bpc_pkg::OP_POLL);
  assign cmd.pop   = deq;
  assign cmd.stamp = deq ? edge_queue[queue_head] : time_ms;
  assign cmd.level = button_level;

  always_ff @(posedge clk) begin
    if (enq) begin
      edge_queue[queue_tail] <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      queue_head     <= '0;
      queue_tail     <= '0;
      queue_fill     <= '0;
    end else begin
      if (edge_ok) begin
        last_edge_time <= time_ms;
      end
      if (enq) begin
        queue_tail <= (queue_tail == bpc_pkg::QPTR_W'(bpc_pkg::QUEUE_DEPTH - 1))
                      ? '0 : queue_tail + bpc_pkg::QPTR_W'(1);
        queue_fill <= queue_fill + bpc_pkg::QFILL_W'(1);
      end
      if (deq) begin
        queue_head <= (queue_head == bpc_pkg::QPTR_W'(bpc_pkg::QUEUE_DEPTH - 1))
                      ? '0 : queue_head + bpc_pkg::QPTR_W'(1);
        queue_fill <= queue_fill - bpc_pkg::QFILL_W'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    queue_fill <= bpc_pkg::QFILL_W'(bpc_pkg::QUEUE_DEPTH))
    else $error("edge queue overfilled");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (edge_ok && queue_fill == bpc_pkg::QFILL_W'(bpc_pkg::QUEUE_DEPTH))
      |=> queue_fill == bpc_pkg::QFILL_W'(bpc_pkg::QUEUE_DEPTH))
    else $error("edge dropped on full queue changed the fill");

endmodule

// File: rtl/core/bpc_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bpc_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpc_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          avail,
  output bpc_pkg::cmd_t head_cmd,
  input  logic          pop
);

  bpc_pkg::cmd_t               slots [bpc_pkg::CMD_DEPTH];
  logic [bpc_pkg::CPTR_W-1:0]  rd_ptr;
  logic [bpc_pkg::CPTR_W-1:0]  wr_ptr;
  logic [bpc_pkg::CCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign full     = (count == bpc_pkg::CCNT_W'(bpc_pkg::CMD_DEPTH));
  assign avail    = (count != '0);
  assign head_cmd = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == bpc_pkg::CPTR_W'(bpc_pkg::CMD_DEPTH - 1))
                  ? '0 : wr_ptr + bpc_pkg::CPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == bpc_pkg::CPTR_W'(bpc_pkg::CMD_DEPTH - 1))
                  ? '0 : rd_ptr + bpc_pkg::CPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + bpc_pkg::CCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - bpc_pkg::CCNT_W'(1);
      end
    end
  end

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command pushed into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + bpc_pkg::CCNT_W'(1))
    else $error("command count out of step");

endmodule

// File: rtl/core/bpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_back
// Counts presses from popped edge times and decides short and long press
// reports at poll time; holds the result in the output register.
// ----------------------------------------------------------------------------
module bpc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  bpc_pkg::cfg_t               cfg,
  input  logic                        cmd_avail,
  input  bpc_pkg::cmd_t               cmd,
  output logic                        cmd_take,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bpc_pkg::COUNT_W-1:0] m_tdata,
  output logic                        m_tuser
);

  logic [bpc_pkg::COUNT_W-1:0] click_count;
  logic [bpc_pkg::COUNT_W-1:0] long_count;
  logic [bpc_pkg::TIME_W-1:0]  last_press_time;

  logic [bpc_pkg::COUNT_W-1:0] click_count_next;
  logic [bpc_pkg::COUNT_W-1:0] long_count_next;
  logic [bpc_pkg::TIME_W-1:0]  last_press_time_next;
  logic                        emit;
  logic                        emit_kind;
  logic [bpc_pkg::COUNT_W-1:0] emit_count;

  logic                        pressed;
  logic [bpc_pkg::TIME_W-1:0]  held;
  logic                        over_long;
  logic                        over_release;

  assign cmd_take     = cmd_avail && (!m_tvalid || m_tready);
  assign pressed      = (cmd.level == cfg.pressed_level);
  assign held         = cmd.stamp - last_press_time;
  assign over_long    = held > {16'd0, cfg.long_threshold_ms};
  assign over_release = held > {16'd0, cfg.release_delay_ms};

  always_comb begin
    click_count_next     = click_count;
    long_count_next      = long_count;
    last_press_time_next = last_press_time;
    emit                 = 1'b0;
    emit_kind            = bpc_pkg::KIND_SHORT;
    emit_count           = click_count;
    if (cmd.pop) begin
      if (pressed) begin
        click_count_next = bpc_pkg::sat_inc(click_count);
        if (over_long) begin
          long_count_next = '0;
        end
      end
      last_press_time_next = cmd.stamp;
    end else if (click_count != '0) begin
      if (pressed && over_long) begin
        long_count_next = bpc_pkg::sat_inc(long_count);
        emit            = 1'b1;
        emit_kind       = bpc_pkg::KIND_LONG;
        emit_count      = bpc_pkg::sat_inc(long_count);
      end else if (!pressed && over_release) begin
        emit             = 1'b1;
        emit_kind        = bpc_pkg::KIND_SHORT;
        emit_count       = click_count;
        long_count_next  = '0;
        click_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_count     <= '0;
      long_count      <= '0;
      last_press_time <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cmd_take) begin
        click_count     <= click_count_next;
        long_count      <= long_count_next;
        last_press_time <= last_press_time_next;
        m_tvalid        <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload: load only with a new report
  always_ff @(posedge clk) begin
    if (cmd_take && emit) begin
      m_tdata <= emit_count;
      m_tuser <= emit_kind;
    end
  end

  a_nonzero_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != '0)
    else $error("press report with zero count");

  a_short_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && emit && emit_kind == bpc_pkg::KIND_SHORT)
      |=> (click_count == '0) && (long_count == '0))
    else $error("short press report left counts set");

endmodule

// File: rtl/core/button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced button edge queue with short and long press detection on polls.
// ----------------------------------------------------------------------------
// Path: a poll accepted on s_tvalid shows its report on m_tvalid after passing
//   through a command queue slot and the back end output register.
// Throughput: one transaction per cycle, edges and polls alike, while the command
//   queue is not full; set by the back end step and the two-entry command queue.
// Reset: synchronous rst clears counts, pointers, timestamps and the output valid;
//   registers return to their defaults; the edge queue store is not cleared.
module button_press_classifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bpc_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] time_ms, [32] button_level
  input  logic                            s_tuser,   // [0] op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bpc_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] press_count
  output logic                            m_tuser,   // [0] press_kind
  input  logic                            cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]       cfg_data
);

  bpc_pkg::cfg_t cfg;
  bpc_pkg::cmd_t push_cmd;
  bpc_pkg::cmd_t head_cmd;
  logic          push;
  logic          full;
  logic          avail;
  logic          take;
  logic          item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms       <= bpc_pkg::DEBOUNCE_RST;
      cfg.long_threshold_ms <= bpc_pkg::LONG_THR_RST;
      cfg.release_delay_ms  <= bpc_pkg::RELEASE_RST;
      cfg.pressed_level     <= bpc_pkg::PRESSED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::REG_DEBOUNCE: cfg.debounce_ms       <= cfg_data;
        bpc_pkg::REG_LONG_THR: cfg.long_threshold_ms <= cfg_data;
        bpc_pkg::REG_RELEASE:  cfg.release_delay_ms  <= cfg_data;
        bpc_pkg::REG_PRESSED:  cfg.pressed_level     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready   = !full;
  assign item_valid = s_tvalid && s_tready;

  bpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .op           (s_tuser),
    .time_ms      (s_tdata[31:0]),
    .button_level (s_tdata[32]),
    .push         (push),
    .cmd          (push_cmd)
  );

  bpc_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .avail    (avail),
    .head_cmd (head_cmd),
    .pop      (take)
  );

  bpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_avail (avail),
    .cmd       (head_cmd),
    .cmd_take  (take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: test/button_press_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_test
// Drives edge and poll transactions into the press classifier, with random
// stalls on both stream sides, and predicts every short and long press
// report. Each accepted report is checked against a scoreboard.
// ----------------------------------------------------------------------------
module button_press_classifier_test;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;

  typedef struct {
    bpc_pkg::kind_t              kind;
    logic [bpc_pkg::COUNT_W-1:0] count;
  } press_t;

  typedef enum int {J_TINY, J_DEBOUNCE, J_LONG, J_RELEASE, J_WILD} jump_t;

  class press_scoreboard;
    bpc_pkg::cfg_t              cfg;
    logic [bpc_pkg::TIME_W-1:0] last_edge;
    logic [bpc_pkg::TIME_W-1:0] last_press;
    logic [bpc_pkg::TIME_W-1:0] edge_store [bpc_pkg::QUEUE_DEPTH];
    int                         fill;
    int                         head;
    logic [bpc_pkg::COUNT_W-1:0] clicks;
    logic [bpc_pkg::COUNT_W-1:0] repeats;
    press_t                     pending [$];
    int                         mismatches;
    int                         shorts_seen;
    int                         longs_seen;

    function new();
      cfg.debounce_ms       = bpc_pkg::DEBOUNCE_RST;
      cfg.long_threshold_ms = bpc_pkg::LONG_THR_RST;
      cfg.release_delay_ms  = bpc_pkg::RELEASE_RST;
      cfg.pressed_level     = bpc_pkg::PRESSED_RST;
      last_edge   = '0;
      last_press  = '0;
      fill        = 0;
      head        = 0;
      clicks      = '0;
      repeats     = '0;
      mismatches  = 0;
      shorts_seen = 0;
      longs_seen  = 0;
    endfunction

    function void write_reg(bpc_pkg::reg_index_t idx, logic [bpc_pkg::CFG_W-1:0] data);
      case (idx)
        bpc_pkg::REG_DEBOUNCE: cfg.debounce_ms       = data;
        bpc_pkg::REG_LONG_THR: cfg.long_threshold_ms = data;
        bpc_pkg::REG_RELEASE:  cfg.release_delay_ms  = data;
        bpc_pkg::REG_PRESSED:  cfg.pressed_level     = data[0];
        default: ;
      endcase
    endfunction

    function void fault(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // Advance the predicted state by one accepted transaction
    function void note_input(bpc_pkg::op_t op, logic [bpc_pkg::TIME_W-1:0] now,
                             logic level);
      logic                       down;
      logic [bpc_pkg::TIME_W-1:0] gap;
      logic [bpc_pkg::TIME_W-1:0] stamp;
      press_t                     rep;
      down = (level == cfg.pressed_level);
      if (op == bpc_pkg::OP_EDGE) begin
        gap = now - last_edge;
        if (gap > bpc_pkg::TIME_W'(cfg.debounce_ms)) begin
          last_edge = now;
          // drop the timestamp when the queue is full
          if (fill < bpc_pkg::QUEUE_DEPTH) begin
            edge_store[(head + fill) % bpc_pkg::QUEUE_DEPTH] = now;
            fill++;
          end
        end
      end else if (fill > 0) begin
        stamp = edge_store[head];
        head  = (head + 1) % bpc_pkg::QUEUE_DEPTH;
        fill--;
        if (down) begin
          if (clicks != '1) clicks++;
          gap = stamp - last_press;
          if (gap > bpc_pkg::TIME_W'(cfg.long_threshold_ms)) repeats = '0;
        end
        last_press = stamp;
      end else if (clicks != '0) begin
        gap = now - last_press;
        if (down && gap > bpc_pkg::TIME_W'(cfg.long_threshold_ms)) begin
          if (repeats != '1) repeats++;
          rep.kind  = bpc_pkg::KIND_LONG;
          rep.count = repeats;
          pending.push_back(rep);
        end else if (!down && gap > bpc_pkg::TIME_W'(cfg.release_delay_ms)) begin
          rep.kind  = bpc_pkg::KIND_SHORT;
          rep.count = clicks;
          pending.push_back(rep);
          repeats = '0;
          clicks  = '0;
        end
      end
    endfunction

    function void check_result(bpc_pkg::kind_t kind, logic [bpc_pkg::COUNT_W-1:0] count);
      press_t want;
      if (kind == bpc_pkg::KIND_LONG) longs_seen++;
      else shorts_seen++;
      if (pending.size() == 0) begin
        fault($sformatf("unexpected report kind %0b count %0d", kind, count));
        return;
      end
      want = pending.pop_front();
      if (want.kind !== kind || want.count !== count)
        fault($sformatf("expected kind %0b count %0d, got kind %0b count %0d",
                        want.kind, want.count, kind, count));
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [bpc_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
  logic                            s_tuser   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [bpc_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                            m_tuser;
  logic                            cfg_we    = 1'b0;
  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_W-1:0]       cfg_data  = '0;

  press_scoreboard            board = new();
  logic [bpc_pkg::TIME_W-1:0] clock_ms = '0;
  int                         items_sent = 0;
  int                         settings = 0;
  int                         src_idle = 14;
  int                         sink_idle = 81;
  int                         cycles = 0;

  button_press_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_result(bpc_pkg::kind_t'(m_tuser), m_tdata);
  end

  // Hold the transaction until the block takes it, then record it
  task automatic send_item(bpc_pkg::op_t op, logic [bpc_pkg::TIME_W-1:0] now, logic level);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= bpc_pkg::S_TDATA_W'({level, now});
    do @(posedge clk); while (!s_tready);
    board.note_input(op, now, level);
    items_sent++;
  endtask

  // Wait until every report is in, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_setting(logic [bpc_pkg::CFG_W-1:0] deb, logic [bpc_pkg::CFG_W-1:0] thr,
                               logic [bpc_pkg::CFG_W-1:0] rel, logic [bpc_pkg::CFG_W-1:0] lvl);
    logic [bpc_pkg::CFG_W-1:0] vals [4];
    vals[0] = deb;
    vals[1] = thr;
    vals[2] = rel;
    vals[3] = lvl;
    settle();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= bpc_pkg::CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      board.write_reg(bpc_pkg::reg_index_t'(i), vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [bpc_pkg::TIME_W-1:0] jump(jump_t j);
    case (j)
      J_TINY:     return bpc_pkg::TIME_W'($urandom_range(0, 3));
      J_DEBOUNCE: return board.cfg.debounce_ms + 1 + $urandom_range(0, 20);
      J_LONG:     return board.cfg.long_threshold_ms + 1 + $urandom_range(0, 20);
      J_RELEASE:  return board.cfg.release_delay_ms + 1 + $urandom_range(0, 20);
      default:    return bpc_pkg::TIME_W'($urandom);
    endcase
  endfunction

  task automatic tick(jump_t j, bpc_pkg::op_t op, logic level);
    clock_ms += jump(j);
    send_item(op, clock_ms, level);
  endtask

  // One or more clicks, each a press and a release, then one or two quiet polls
  task automatic click_sequence();
    logic down;
    int   n;
    down = board.cfg.pressed_level;
    n    = $urandom_range(1, 4);
    repeat (n) begin
      tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
      if ($urandom_range(0, 2) == 0) tick(J_TINY, bpc_pkg::OP_EDGE, 1'($urandom));
      tick(J_TINY, bpc_pkg::OP_POLL, down);
      tick(($urandom_range(0, 4) == 0) ? J_TINY : J_DEBOUNCE, bpc_pkg::OP_EDGE,
           1'($urandom));
      tick(J_TINY, bpc_pkg::OP_POLL, ~down);
    end
    tick(($urandom_range(0, 3) == 0) ? J_TINY : J_RELEASE, bpc_pkg::OP_POLL, ~down);
    if ($urandom_range(0, 1) == 0) tick(J_RELEASE, bpc_pkg::OP_POLL, ~down);
  endtask

  // Press and keep holding, mostly across the long threshold
  task automatic hold_sequence(int polls);
    logic down;
    down = board.cfg.pressed_level;
    tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
    tick(J_TINY, bpc_pkg::OP_POLL, down);
    tick(($urandom_range(0, 4) == 0) ? J_TINY : J_LONG, bpc_pkg::OP_POLL, down);
    repeat (polls) tick(J_TINY, bpc_pkg::OP_POLL, down);
    tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
    tick(J_TINY, bpc_pkg::OP_POLL, ~down);
    tick(J_RELEASE, bpc_pkg::OP_POLL, ~down);
  endtask

  // Overfill the edge queue, then drain some or all of it
  task automatic edge_burst();
    int n;
    n = $urandom_range(17, 20);
    repeat (n) tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
    n = $urandom_range(2, 20);
    repeat (n) tick(J_TINY, bpc_pkg::OP_POLL, 1'($urandom));
  endtask

  task automatic noise_item();
    jump_t j;
    j = jump_t'($urandom_range(0, 4));
    tick(j, bpc_pkg::op_t'($urandom_range(0, 1)), 1'($urandom));
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) click_sequence();
    else if (pick < 72) hold_sequence($urandom_range(0, 6));
    else if (pick < 80) edge_burst();
    else noise_item();
  endtask

  task automatic saturate_clicks();
    logic down;
    down = board.cfg.pressed_level;
    repeat (260) begin
      tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
      tick(J_TINY, bpc_pkg::OP_POLL, down);
    end
    tick(J_DEBOUNCE, bpc_pkg::OP_EDGE, 1'($urandom));
    tick(J_TINY, bpc_pkg::OP_POLL, ~down);
    tick(J_RELEASE, bpc_pkg::OP_POLL, ~down);
  endtask

  initial begin
    int goal;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: debounce 50, long 1000, release 300, pressed low
    send_item(bpc_pkg::OP_EDGE, 32'd10, 1'b1);          // inside debounce of time zero
    send_item(bpc_pkg::OP_POLL, 32'd20, 1'b1);          // nothing counted yet
    send_item(bpc_pkg::OP_EDGE, 32'd100, 1'b0);
    send_item(bpc_pkg::OP_EDGE, 32'd120, 1'b1);         // bounce, filtered
    send_item(bpc_pkg::OP_POLL, 32'd130, 1'b0);         // pop, one click
    send_item(bpc_pkg::OP_POLL, 32'd500, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'd1200, 1'b0);        // long press
    send_item(bpc_pkg::OP_POLL, 32'd1300, 1'b0);        // long press, repeat two
    send_item(bpc_pkg::OP_EDGE, 32'd1400, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'd1410, 1'b1);        // pop released edge
    send_item(bpc_pkg::OP_POLL, 32'd1600, 1'b1);
    send_item(bpc_pkg::OP_POLL, 32'd1800, 1'b1);        // short press, one click
    send_item(bpc_pkg::OP_POLL, 32'd2000, 1'b1);
    send_item(bpc_pkg::OP_EDGE, 32'hFFFF_FFF0, 1'b0);
    send_item(bpc_pkg::OP_EDGE, 32'h0000_0030, 1'b1);   // gap across the wrap
    send_item(bpc_pkg::OP_POLL, 32'h0000_0031, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'h0000_0032, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'h0000_0400, 1'b1);   // short press, two clicks
    send_item(bpc_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1);
    send_item(bpc_pkg::OP_EDGE, 32'h0000_0000, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b0);
    send_item(bpc_pkg::OP_POLL, 32'h0000_1000, 1'b0);   // long press after wrap

    for (int s = 0; s < 6; s++) begin
      src_idle  = (s < 2) ? 14 : (s < 4) ? 81 : 0;
      sink_idle = (s < 2) ? 81 : (s < 4) ? 14 : 0;
      case (s)
        0: apply_setting(16'd0, 16'd0, 16'd0, 16'hFFFF);
        1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        default: begin
          apply_setting(($urandom_range(0, 3) == 0) ? bpc_pkg::CFG_W'($urandom) :
                          bpc_pkg::CFG_W'($urandom_range(0, 200)),
                        ($urandom_range(0, 3) == 0) ? bpc_pkg::CFG_W'($urandom) :
                          bpc_pkg::CFG_W'($urandom_range(0, 3000)),
                        ($urandom_range(0, 3) == 0) ? bpc_pkg::CFG_W'($urandom) :
                          bpc_pkg::CFG_W'($urandom_range(0, 1000)),
                        bpc_pkg::CFG_W'($urandom));
        end
      endcase
      if (s == 4) saturate_clicks();
      if (s == 5) hold_sequence(260);
      goal = 22 + RANDOM_ITEMS * (s + 1) / 6;
      while (items_sent < goal) random_sequence();
    end

    settle();
    repeat (4 * SETTLE) @(posedge clk);
    if (board.pending.size() != 0)
      board.fault($sformatf("%0d reports never arrived", board.pending.size()));

    $display("run: %0d transactions over %0d register settings, stalls in both orders",
             items_sent, settings + 1);
    $display("run: %0d short and %0d long press reports checked, %0d mismatches",
             board.shorts_seen, board.longs_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_front.sv
rtl/core/bpc_cmd_fifo.sv
rtl/core/bpc_back.sv
rtl/core/button_press_classifier.sv
test/button_press_classifier_test.sv
